FILE: hdl/mwg_pkg.sv
`default_nettype none
package mwg_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = $clog2(CHANNELS + 1);
  localparam int CMP_W    = (CNT_W > 3) ? CNT_W : 3;

  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
  // keep only the phase bits that select a sine entry
  localparam logic [31:0] SINE_MASK = ~((32'h1 << (32 - SINE_BITS)) - 32'h1);

  localparam logic [16:0] COEF_A1   = 17'd102944;
  localparam logic [15:0] COEF_A3   = 16'd42334;
  localparam logic [12:0] COEF_A5   = 13'd4926;
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  localparam logic [2:0] ACT_ADD      = 3'd0;
  localparam logic [2:0] ACT_SET_WAVE = 3'd1;
  localparam logic [2:0] ACT_SET_FREQ = 3'd2;
  localparam logic [2:0] ACT_SET_AMP  = 3'd3;
  localparam logic [2:0] ACT_SET_PH   = 3'd4;
  localparam logic [2:0] ACT_TICK     = 3'd5;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_TRI    = 2'd1;
  localparam logic [1:0] WAVE_SAW    = 2'd2;
  localparam logic [1:0] WAVE_SQUARE = 2'd3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_RATE = 2'd1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic [2:0]         act;
    logic [CH_BITS-1:0] ch;
    logic [7:0]         pin;
    logic [1:0]         wave;
    logic [31:0]        freq;
    logic [15:0]        amp;
    logic [15:0]        phase;
    logic [19:0]        elapsed;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  pin;
    logic [2:0]  channel;
    logic [15:0] duty;
    logic [19:0] pwm_freq;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/mwg_front.sv
`default_nettype none
module mwg_front import mwg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [2:0]         in_channel,
  input  logic [7:0]         in_pin,
  input  logic [1:0]         in_wave_type,
  input  logic [31:0]        in_freq_step,
  input  logic signed [15:0] in_amplitude,
  input  logic [15:0]        in_phase_offset,
  input  logic [19:0]        in_elapsed_us,
  input  logic [15:0]        max_duty,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  logic [CNT_W-1:0] cnt_r;
  logic             accept;
  logic             keep;
  logic             ch_ok;
  logic             tab_full;
  logic [15:0]      amp_clamped;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign tab_full = (cnt_r == CNT_W'(CHANNELS));
  assign ch_ok    = (CMP_W'(in_channel) < CMP_W'(cnt_r));

  always_comb begin
    if (in_amplitude[15]) begin
      amp_clamped = 16'h0;
    end else if (in_amplitude > max_duty) begin
      amp_clamped = max_duty;
    end else begin
      amp_clamped = in_amplitude;
    end
  end

  // drop adds to a full table, setters for unadded channels, empty or channel-less ticks, and unknown actions
  always_comb begin
    unique case (in_action)
      ACT_ADD:      keep = !tab_full;
      ACT_SET_WAVE,
      ACT_SET_FREQ,
      ACT_SET_AMP,
      ACT_SET_PH:   keep = ch_ok;
      ACT_TICK:     keep = (in_elapsed_us != 20'h0) && (cnt_r != '0);
      default:      keep = 1'b0;
    endcase
  end

  assign q_push        = accept && keep;
  assign q_cmd.act     = in_action;
  assign q_cmd.ch      = CH_BITS'(in_channel);
  assign q_cmd.pin     = in_pin;
  assign q_cmd.wave    = in_wave_type;
  assign q_cmd.freq    = in_freq_step;
  assign q_cmd.amp     = amp_clamped;
  assign q_cmd.phase   = in_phase_offset;
  assign q_cmd.elapsed = in_elapsed_us;

  // shadow of the channel count so setters can be checked at the door
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push && in_action == ACT_ADD) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mwg_queue.sv
`default_nettype none
module mwg_queue import mwg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     count_r;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mwg_back.sv
`default_nettype none
module mwg_back import mwg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  input  logic [19:0] pwm_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        res
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_ACC   = 4'd2;
  localparam logic [3:0] ST_PH    = 4'd3;
  localparam logic [3:0] ST_Q1    = 4'd4;
  localparam logic [3:0] ST_Q2    = 4'd5;
  localparam logic [3:0] ST_Q3    = 4'd6;
  localparam logic [3:0] ST_Q4    = 4'd7;
  localparam logic [3:0] ST_SHAPE = 4'd8;
  localparam logic [3:0] ST_DUTY  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [7:0]  pin_tab   [CHANNELS];
  logic [1:0]  wave_tab  [CHANNELS];
  logic [31:0] freq_tab  [CHANNELS];
  logic [15:0] amp_tab   [CHANNELS];
  logic [15:0] phase_tab [CHANNELS];
  logic [31:0] acc_tab   [CHANNELS];

  logic [3:0]         state_r;
  logic [3:0]         state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CH_BITS-1:0] k_r;
  logic               out_valid_r;
  res_t               res_r;

  logic [19:0] elapsed_r;
  logic [31:0] prod_r;
  logic [31:0] p_r;
  logic [16:0] u_r;
  logic [16:0] u2_r;
  logic [15:0] s1_r;
  logic [16:0] s2_r;
  logic [17:0] q_r;
  logic [16:0] v_r;
  logic [15:0] duty_r;

  logic [51:0]        mul_step;
  logic [31:0]        t_c;
  logic [16:0]        u_c;
  logic [33:0]        mul_sq;
  logic [29:0]        mul_a5;
  logic [32:0]        mul_a3;
  logic [33:0]        mul_a1;
  logic [32:0]        mul_amp;
  logic [31:0]        tri_d;
  logic [18:0]        sine_sum;
  logic [16:0]        v_c;
  logic               out_free;
  logic               is_last;
  logic [CH_BITS-1:0] add_idx;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_free  = !out_valid_r || !out_stall;
  assign is_last   = ((CNT_W'(k_r) + CNT_W'(1)) == cnt_r);
  assign add_idx   = CH_BITS'(cnt_r);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign mul_step = 52'(freq_tab[k_r]) * 52'(elapsed_r);
  assign t_c      = p_r & SINE_MASK;
  // odd quadrants run the quarter wave backward
  assign u_c      = p_r[30] ? (ONE_Q16 - {1'b0, t_c[29:14]}) : {1'b0, t_c[29:14]};
  assign mul_sq   = 34'(u_c) * 34'(u_c);
  assign mul_a5   = 30'(COEF_A5) * 30'(u2_r);
  assign mul_a3   = 33'(s1_r) * 33'(u2_r);
  assign mul_a1   = 34'(s2_r) * 34'(u_r);
  assign mul_amp  = 33'(v_r) * 33'(amp_tab[k_r]);
  assign tri_d    = p_r[31] ? (p_r - HALF_TURN) : (HALF_TURN - p_r);
  assign sine_sum = p_r[31] ? (19'(ONE_Q16) - 19'(q_r)) : (19'(ONE_Q16) + 19'(q_r));

  always_comb begin
    unique case (wave_tab[k_r])
      WAVE_SINE:   v_c = sine_sum[17:1];
      WAVE_TRI:    v_c = tri_d[31:15];
      WAVE_SAW:    v_c = {1'b0, p_r[31:16]};
      WAVE_SQUARE: v_c = (!p_r[31] || q_r == '0) ? ONE_Q16 : 17'h0;
      default:     v_c = 17'h0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_pop && q_head.act == ACT_TICK) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_PH;
      ST_PH:    state_nxt = ST_Q1;
      ST_Q1:    state_nxt = ST_Q2;
      ST_Q2:    state_nxt = ST_Q3;
      ST_Q3:    state_nxt = ST_Q4;
      ST_Q4:    state_nxt = ST_SHAPE;
      ST_SHAPE: state_nxt = ST_DUTY;
      ST_DUTY:  state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = is_last ? ST_IDLE : ST_MUL;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // channel table writes
  always_ff @(posedge clk) begin
    if (q_pop) begin
      unique case (q_head.act)
        ACT_ADD: begin
          pin_tab[add_idx]   <= q_head.pin;
          wave_tab[add_idx]  <= q_head.wave;
          freq_tab[add_idx]  <= q_head.freq;
          amp_tab[add_idx]   <= q_head.amp;
          phase_tab[add_idx] <= q_head.phase;
          acc_tab[add_idx]   <= 32'h0;
        end
        ACT_SET_WAVE: wave_tab[q_head.ch]  <= q_head.wave;
        ACT_SET_FREQ: freq_tab[q_head.ch]  <= q_head.freq;
        ACT_SET_AMP:  amp_tab[q_head.ch]   <= q_head.amp;
        ACT_SET_PH:   phase_tab[q_head.ch] <= q_head.phase;
        default: ;
      endcase
    end else if (state_r == ST_ACC) begin
      acc_tab[k_r] <= acc_tab[k_r] + prod_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE:  if (q_pop) elapsed_r <= q_head.elapsed;
      ST_MUL:   prod_r <= mul_step[31:0];
      ST_PH:    p_r <= acc_tab[k_r] + {phase_tab[k_r], 16'h0};
      ST_Q1: begin
        u_r  <= u_c;
        u2_r <= mul_sq[32:16];
      end
      ST_Q2:    s1_r <= COEF_A3 - 16'(mul_a5[29:16]);
      ST_Q3:    s2_r <= COEF_A1 - 17'(mul_a3[32:16]);
      ST_Q4:    q_r <= mul_a1[33:16];
      ST_SHAPE: v_r <= v_c;
      ST_DUTY:  duty_r <= mul_amp[31:16];
      ST_OUT: begin
        if (out_free) begin
          res_r.pin      <= pin_tab[k_r];
          res_r.channel  <= 3'(k_r);
          res_r.duty     <= duty_r;
          res_r.pwm_freq <= pwm_rate;
          res_r.last     <= is_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_head.act == ACT_ADD) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (q_pop) begin
        k_r <= '0;
      end else if (state_r == ST_OUT && out_free && !is_last) begin
        k_r <= k_r + CH_BITS'(1);
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/multichannel_waveform_generator_core.sv
// An add or setter is queued on acceptance and lands in the channel tables when the back end
// pops it; the back end pops only while idle, and a tick then walks every channel in turn.
// Each channel steps through multiply, accumulate, phase, four polynomial steps, shape, scale,
// output; a stalled result holds it. No queued request is popped until a tick's last result is out.
// Reset (rst_n low, synchronous): channel count zero, queue empty, no result pending,
// max_duty 255, pwm_rate 1000. Channel tables are not cleared.
`default_nettype none
module multichannel_waveform_generator_core import mwg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_action,
  input  logic [2:0]           in_channel,
  input  logic [7:0]           in_pin,
  input  logic [1:0]           in_wave_type,
  input  logic [31:0]          in_freq_step,
  input  logic signed [15:0]   in_amplitude,
  input  logic [15:0]          in_phase_offset,
  input  logic [19:0]          in_elapsed_us,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_pin,
  output logic [2:0]           out_channel,
  output logic [15:0]          out_duty,
  output logic [19:0]          out_pwm_frequency,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [19:0]          cfg_data
);

  logic [15:0] max_duty_r;
  logic [19:0] pwm_rate_r;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  cmd_t        q_cmd;
  cmd_t        q_head;
  res_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_duty_r <= 16'd255;
      pwm_rate_r <= 20'd1000;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAX_DUTY) begin
        max_duty_r <= cfg_data[15:0];
      end else if (cfg_index == CFG_PWM_RATE) begin
        pwm_rate_r <= cfg_data;
      end
    end
  end

  mwg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_channel      (in_channel),
    .in_pin          (in_pin),
    .in_wave_type    (in_wave_type),
    .in_freq_step    (in_freq_step),
    .in_amplitude    (in_amplitude),
    .in_phase_offset (in_phase_offset),
    .in_elapsed_us   (in_elapsed_us),
    .max_duty        (max_duty_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  mwg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  mwg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .pwm_rate  (pwm_rate_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_pin           = res.pin;
  assign out_channel       = res.channel;
  assign out_duty          = res.duty;
  assign out_pwm_frequency = res.pwm_freq;
  assign out_last          = res.last;

endmodule
`default_nettype wire

FILE: hdl/mwg_checker.sv
`default_nettype none
module mwg_checker import mwg_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_channel,
  input logic       out_last
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result keeps its channel and last flag
  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_channel) && $stable(out_last))
    else $error("stalled result changed");

  a_top_channel_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_channel == 3'(CHANNELS - 1) |-> out_last)
    else $error("highest channel not marked last");

endmodule

bind multichannel_waveform_generator_core mwg_checker u_mwg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_channel (out_channel),
  .out_last    (out_last)
);
`default_nettype wire
